FILE: src/egacc_pkg.sv
package egacc_pkg;

    localparam int ADDR_W = 28;

    localparam logic [1:0] CMD_ACC    = 2'd0;
    localparam logic [1:0] CMD_RD_TOK = 2'd1;
    localparam logic [1:0] CMD_RD_POS = 2'd2;

    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;

    typedef enum logic [1:0] {
        KIND_ACC,
        KIND_RD_TOK,
        KIND_RD_POS
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [ADDR_W-1:0]  ti;
        logic [ADDR_W-1:0]  pi;
        logic               tok_ok;
        logic               pos_ok;
        logic [31:0]        value;
    } item_t;

endpackage

FILE: src/egacc_ram.sv
module egacc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/egacc_fadd.sv
module egacc_fadd (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [31:0] sum
);

    // stage 1: specials, ordering, alignment
    logic        sa, sb;
    logic [7:0]  ea, eb, ea1, eb1, eg, es, d;
    logic [26:0] ma, mb, mg, ms, msh;
    logic        swap;
    logic        spec;
    logic [31:0] spec_val;

    always_comb
    begin
        sa = a[31];
        sb = b[31];
        ea = a[30:23];
        eb = b[30:23];
        spec = 1'b1;
        spec_val = 32'd0;
        if (((&ea) && (|a[22:0])) || ((&eb) && (|b[22:0])))
        begin
            spec_val = egacc_pkg::QNAN_BITS;
        end
        else if ((&ea) && (&eb))
        begin
            spec_val = (sa == sb) ? a : egacc_pkg::QNAN_BITS;
        end
        else if (&ea)
        begin
            spec_val = a;
        end
        else if (&eb)
        begin
            spec_val = b;
        end
        else if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
        begin
            spec_val = {sa & sb, 31'd0};
        end
        else if (a[30:0] == 31'd0)
        begin
            spec_val = b;
        end
        else if (b[30:0] == 31'd0)
        begin
            spec_val = a;
        end
        else
        begin
            spec = 1'b0;
        end
        ea1 = (ea == 8'd0) ? 8'd1 : ea;
        eb1 = (eb == 8'd0) ? 8'd1 : eb;
        ma = {ea != 8'd0, a[22:0], 3'b000};
        mb = {eb != 8'd0, b[22:0], 3'b000};
        swap = (eb1 > ea1) || (eb1 == ea1 && mb > ma);
        eg = swap ? eb1 : ea1;
        es = swap ? ea1 : eb1;
        mg = swap ? mb : ma;
        ms = swap ? ma : mb;
        d = eg - es;
        if (d >= 8'd27)
        begin
            msh = {26'd0, |ms};
        end
        else
        begin
            msh = (ms >> d) | {26'd0, |(ms & ((27'd1 << d) - 27'd1))};
        end
    end

    logic        v1_reg, s1_reg, sub1_reg, spec1_reg;
    logic [8:0]  e1_reg;
    logic [26:0] ma1_reg, mb1_reg;
    logic [31:0] val1_reg;

    // stage 2: add or subtract
    logic [27:0] sum2;
    logic [26:0] diff2, m2;
    logic [8:0]  e2;

    always_comb
    begin
        sum2 = {1'b0, ma1_reg} + {1'b0, mb1_reg};
        diff2 = ma1_reg - mb1_reg;
        e2 = e1_reg;
        if (sub1_reg)
        begin
            m2 = diff2;
        end
        else if (sum2[27])
        begin
            m2 = sum2[27:1] | {26'd0, sum2[0]};
            e2 = e1_reg + 9'd1;
        end
        else
        begin
            m2 = sum2[26:0];
        end
    end

    logic        v2_reg, s2_reg, sub2_reg, spec2_reg;
    logic [8:0]  e2_reg;
    logic [26:0] m2_reg;
    logic [31:0] val2_reg;

    // stage 3: leading zero count
    logic [4:0] lz;
    logic [8:0] emax;
    logic [4:0] sh3;

    always_comb
    begin
        lz = 5'd26;
        for (int i = 0; i < 27; i++)
        begin
            if (m2_reg[i])
            begin
                lz = 5'(26 - i);
            end
        end
        emax = e2_reg - 9'd1;
        if (!sub2_reg)
        begin
            sh3 = 5'd0;
        end
        else if ({4'd0, lz} < emax)
        begin
            sh3 = lz;
        end
        else
        begin
            sh3 = emax[4:0];
        end
    end

    logic        v3_reg, s3_reg, spec3_reg;
    logic [8:0]  e3_reg;
    logic [26:0] m3_reg;
    logic [4:0]  sh3_reg;
    logic [31:0] val3_reg;

    // stage 4: normalize, round, pack
    logic [26:0] mn;
    logic [8:0]  en, ef;
    logic [2:0]  rb;
    logic        up;
    logic [24:0] r25;
    logic [23:0] mf;
    logic [31:0] res4;

    always_comb
    begin
        mn = m3_reg << sh3_reg;
        en = e3_reg - {4'd0, sh3_reg};
        rb = mn[2:0];
        up = (rb > 3'd4) || (rb == 3'd4 && mn[3]);
        r25 = {1'b0, mn[26:3]} + {24'd0, up};
        if (r25[24])
        begin
            mf = r25[24:1];
            ef = en + 9'd1;
        end
        else
        begin
            mf = r25[23:0];
            ef = en;
        end
        if (spec3_reg)
        begin
            res4 = val3_reg;
        end
        else if (ef >= 9'd255)
        begin
            res4 = {s3_reg, 8'hFF, 23'd0};
        end
        else if (!mf[23])
        begin
            res4 = {s3_reg, 8'd0, mf[22:0]};
        end
        else
        begin
            res4 = {s3_reg, ef[7:0], mf[22:0]};
        end
    end

    logic        v4_reg;
    logic [31:0] res4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg    <= swap ? sb : sa;
        sub1_reg  <= sa != sb;
        spec1_reg <= spec;
        val1_reg  <= spec_val;
        e1_reg    <= {1'b0, eg};
        ma1_reg   <= mg;
        mb1_reg   <= msh;

        s2_reg    <= s1_reg;
        sub2_reg  <= sub1_reg;
        spec2_reg <= spec1_reg || (sub1_reg && diff2 == 27'd0);
        val2_reg  <= spec1_reg ? val1_reg : 32'd0;
        e2_reg    <= e2;
        m2_reg    <= m2;

        s3_reg    <= s2_reg;
        spec3_reg <= spec2_reg;
        val3_reg  <= val2_reg;
        e3_reg    <= e2_reg;
        m3_reg    <= m2_reg;
        sh3_reg   <= sh3;

        res4_reg  <= res4;
    end

    assign done = v4_reg;
    assign sum  = res4_reg;

endmodule

FILE: src/egacc_front.sv
module egacc_front #(
    parameter int NUM_TOKENS    = 1024,
    parameter int MAX_POSITIONS = 256,
    parameter int ROW_LEN       = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  logic [1:0]          command,
    input  logic [9:0]          token,
    input  logic [7:0]          position,
    input  logic [4:0]          element,
    input  logic [31:0]         grad_value,
    input  logic                clearing,
    output logic                q_valid,
    output egacc_pkg::item_t    q_item,
    input  logic                q_pop
);

    egacc_pkg::item_t item;
    logic [31:0]      ti_full, pi_full;
    logic             col_ok;
    logic             accept, push;

    egacc_pkg::item_t q_mem_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       cnt_reg;

    always_comb
    begin
        ti_full = 32'(token) * 32'(ROW_LEN) + 32'(element);
        pi_full = 32'(position) * 32'(ROW_LEN) + 32'(element);
        col_ok = 32'(element) < 32'(ROW_LEN);
        item.ti = ti_full[egacc_pkg::ADDR_W-1:0];
        item.pi = pi_full[egacc_pkg::ADDR_W-1:0];
        item.tok_ok = col_ok && (32'(token) < 32'(NUM_TOKENS));
        item.pos_ok = col_ok && (32'(position) < 32'(MAX_POSITIONS));
        item.value = grad_value;
        case (command)
            egacc_pkg::CMD_RD_TOK: item.kind = egacc_pkg::KIND_RD_TOK;
            egacc_pkg::CMD_RD_POS: item.kind = egacc_pkg::KIND_RD_POS;
            default:               item.kind = egacc_pkg::KIND_ACC;
        endcase
    end

    assign cmd_stall = clearing || (cnt_reg == 2'd2);
    assign accept    = cmd_valid && !cmd_stall;
    // unused command code is taken and dropped
    assign push      = accept && (command == egacc_pkg::CMD_ACC
                                  || command == egacc_pkg::CMD_RD_TOK
                                  || command == egacc_pkg::CMD_RD_POS);

    assign q_valid = cnt_reg != 2'd0;
    assign q_item  = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !q_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (q_pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

FILE: src/egacc_back.sv
module egacc_back #(
    parameter int NUM_TOKENS    = 1024,
    parameter int MAX_POSITIONS = 256,
    parameter int ROW_LEN       = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    output logic                clearing,
    input  logic                q_valid,
    input  egacc_pkg::item_t    q_item,
    output logic                q_pop,
    output logic                entry_valid,
    input  logic                entry_stall,
    output logic [31:0]         entry_value
);

    localparam int TDEPTH = NUM_TOKENS * ROW_LEN;
    localparam int PDEPTH = MAX_POSITIONS * ROW_LEN;
    localparam int TA_W   = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
    localparam int PA_W   = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
    localparam int MAXD   = (TDEPTH > PDEPTH) ? TDEPTH : PDEPTH;
    localparam int CLR_W  = $clog2(MAXD);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DATA,
        ST_ADD
    } state_t;

    state_t           state_reg, state_next;
    logic [CLR_W-1:0] clr_cnt_reg, clr_cnt_next;
    egacc_pkg::item_t cur_reg, cur_next;
    logic             out_valid_reg, out_valid_next;
    logic [31:0]      out_data_reg, out_data_next;

    logic             t_we, p_we, re;
    logic [TA_W-1:0]  t_waddr, t_raddr;
    logic [PA_W-1:0]  p_waddr, p_raddr;
    logic [31:0]      t_wdata, p_wdata, t_rdata, p_rdata;
    logic             add_start, t_done, p_done;
    logic [31:0]      t_sum, p_sum;
    logic             out_free;

    egacc_ram #(.WIDTH(32), .DEPTH(TDEPTH)) u_tok_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .re    (re),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    egacc_ram #(.WIDTH(32), .DEPTH(PDEPTH)) u_pos_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .re    (re),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    egacc_fadd u_tok_add (
        .clk   (clk),
        .rst_n (rst_n),
        .start (add_start),
        .a     (t_rdata),
        .b     (cur_reg.value),
        .done  (t_done),
        .sum   (t_sum)
    );

    egacc_fadd u_pos_add (
        .clk   (clk),
        .rst_n (rst_n),
        .start (add_start),
        .a     (p_rdata),
        .b     (cur_reg.value),
        .done  (p_done),
        .sum   (p_sum)
    );

    assign t_raddr  = q_item.ti[TA_W-1:0];
    assign p_raddr  = q_item.pi[PA_W-1:0];
    assign clearing = state_reg == ST_CLEAR;
    assign out_free = !out_valid_reg || !entry_stall;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && entry_stall;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        re             = 1'b0;
        add_start      = 1'b0;
        t_we           = 1'b0;
        p_we           = 1'b0;
        t_waddr        = cur_reg.ti[TA_W-1:0];
        p_waddr        = cur_reg.pi[PA_W-1:0];
        t_wdata        = 32'd0;
        p_wdata        = 32'd0;
        case (state_reg)
            ST_CLEAR:
            begin
                t_waddr = clr_cnt_reg[TA_W-1:0];
                p_waddr = clr_cnt_reg[PA_W-1:0];
                t_we = {1'b0, clr_cnt_reg} < (CLR_W+1)'(TDEPTH);
                p_we = {1'b0, clr_cnt_reg} < (CLR_W+1)'(PDEPTH);
                clr_cnt_next = clr_cnt_reg + CLR_W'(1);
                if ({1'b0, clr_cnt_reg} == (CLR_W+1)'(MAXD - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    re = 1'b1;
                    cur_next = q_item;
                    state_next = ST_DATA;
                end
            end
            ST_DATA:
            begin
                case (cur_reg.kind)
                    egacc_pkg::KIND_ACC:
                    begin
                        add_start = 1'b1;
                        state_next = ST_ADD;
                    end
                    egacc_pkg::KIND_RD_TOK:
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            out_data_next = cur_reg.tok_ok ? t_rdata : 32'd0;
                            t_we = cur_reg.tok_ok;
                            state_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            out_data_next = cur_reg.pos_ok ? p_rdata : 32'd0;
                            p_we = cur_reg.pos_ok;
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end
            default:
            begin
                t_wdata = t_sum;
                p_wdata = p_sum;
                if (t_done && p_done)
                begin
                    t_we = cur_reg.tok_ok;
                    p_we = cur_reg.pos_ok;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= 32'd0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign entry_valid = out_valid_reg;
    assign entry_value = out_data_reg;

endmodule

FILE: src/embedding_gradient_accumulator.sv
// a read beat goes through the command queue, the store read and the output register
// the back end finishes one read or accumulate before taking the next; an accumulate is a
// read, a 4-stage fp add and a write back through the single write port of each store
// reset: a clearing pass zeroes both stores, stepping an address counter up to
// max(NUM_TOKENS, MAX_POSITIONS) * ROW_LEN - 1, with cmd_stall held high until it ends
module embedding_gradient_accumulator #(
    parameter int NUM_TOKENS    = 1024,
    parameter int MAX_POSITIONS = 256,
    parameter int ROW_LEN       = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [1:0]  command,
    input  logic [9:0]  token,
    input  logic [7:0]  position,
    input  logic [4:0]  element,
    input  logic [31:0] grad_value,
    output logic        entry_valid,
    input  logic        entry_stall,
    output logic [31:0] entry_value
);

    logic             clearing;
    logic             q_valid, q_pop;
    egacc_pkg::item_t q_item;

    egacc_front #(
        .NUM_TOKENS    (NUM_TOKENS),
        .MAX_POSITIONS (MAX_POSITIONS),
        .ROW_LEN       (ROW_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .command    (command),
        .token      (token),
        .position   (position),
        .element    (element),
        .grad_value (grad_value),
        .clearing   (clearing),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    egacc_back #(
        .NUM_TOKENS    (NUM_TOKENS),
        .MAX_POSITIONS (MAX_POSITIONS),
        .ROW_LEN       (ROW_LEN)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .clearing    (clearing),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .entry_valid (entry_valid),
        .entry_stall (entry_stall),
        .entry_value (entry_value)
    );

endmodule
